[src/calendar_clock_counter_assert.svh]
// ----------------------------------------------------------------------------
// Calendar clock counter assertion macros
// Concurrent check helpers for the calendar clock RTL.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_COUNTER_ASSERT_SVH
`define CALENDAR_CLOCK_COUNTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CCC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ccc_pkg.sv]
// ----------------------------------------------------------------------------
// Calendar clock counter package
// Beat types, command codes, decimal split constants and the month table.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_SET_DATE = 2'd1;
  localparam logic [1:0] FUNC_SET_TIME = 2'd2;

  // floor(v / 10000) = (v * RECIP_TENK) >> SHIFT_TENK for v < 2**27
  localparam logic [27:0] RECIP_TENK    = 28'd219902326;
  localparam int unsigned SHIFT_TENK    = 41;
  // floor(x / 100) = (x * RECIP_HUNDRED) >> SHIFT_HUNDRED for x < 2**14
  localparam logic [14:0] RECIP_HUNDRED = 15'd20972;
  localparam int unsigned SHIFT_HUNDRED = 21;

  localparam logic [5:0]  SEC_MAX   = 6'd59;
  localparam logic [5:0]  MIN_MAX   = 6'd59;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [3:0]  MONTH_MAX = 4'd12;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;

  localparam logic [4:0] MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                            5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  typedef struct packed {
    logic [1:0]  func;
    logic [26:0] set_value;
  } in_t;

  typedef struct packed {
    logic [5:0]  second_now;
    logic [5:0]  minute_now;
    logic [4:0]  hour_now;
    logic [4:0]  day_now;
    logic [3:0]  month_now;
    logic [13:0] year_now;
    logic        minute_done;
    logic        accepted;
  } out_t;

  // decoded command handed from the split pipeline to the clock state
  typedef struct packed {
    logic [1:0]  func;
    logic        load;    // set value passed its range check
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } cmd_t;

  function automatic logic [4:0] days_in(input logic [3:0] month);
    logic [3:0] idx;
    idx = month - 4'd1;
    if (month >= 4'd1 && month <= MONTH_MAX) begin
      return MONTH_LEN[idx];
    end
    return 5'd31;
  endfunction

endpackage

`default_nettype wire

[src/calendar_clock_counter.sv]
// An accepted input beat passes the input register and three split stages, then
// the clock state and result register, before its result beat is raised.
// Throughput: one beat per cycle while out_stall_i is low; the stages drain
// independently so bubbles collapse under stall.
// Reset (async, active low): 00:00:00 on day 1, month 1, year 0, pipeline empty.
// ----------------------------------------------------------------------------
// Calendar clock counter
// Seconds-to-years clock with tick, set-date and set-time commands.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_clock_counter
  import ccc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_o
);

`include "calendar_clock_counter_assert.svh"

  logic  cmd_valid;
  logic  take;
  cmd_t  cmd;

  ccc_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (take),
    .cmd_o       (cmd)
  );

  logic [5:0]  sec_q,  sec_d;
  logic [5:0]  min_q,  min_d;
  logic [4:0]  hour_q, hour_d;
  logic [4:0]  day_q,  day_d;
  logic [3:0]  mon_q,  mon_d;
  logic [13:0] year_q, year_d;
  logic        out_valid_q;
  out_t        out_q, out_d;
  logic        fire;

  assign take = !out_valid_q || !out_stall_i;
  assign fire = cmd_valid && take;

  logic sec_wrap, min_wrap, hour_wrap, day_wrap, mon_wrap, year_wrap;

  always_comb begin
    // carry chain, state is always in range
    sec_wrap  = (sec_q == SEC_MAX);
    min_wrap  = sec_wrap && (min_q == MIN_MAX);
    hour_wrap = min_wrap && (hour_q == HOUR_MAX);
    day_wrap  = hour_wrap && (day_q == days_in(mon_q));
    mon_wrap  = day_wrap && (mon_q == MONTH_MAX);
    year_wrap = mon_wrap && (year_q == YEAR_MAX);

    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    day_d  = day_q;
    mon_d  = mon_q;
    year_d = year_q;
    out_d.minute_done = 1'b0;
    out_d.accepted    = 1'b0;

    case (cmd.func)
      FUNC_TICK: begin
        out_d.minute_done = sec_wrap;
        out_d.accepted    = 1'b1;
        sec_d = sec_wrap ? 6'd0 : sec_q + 6'd1;
        if (sec_wrap)  min_d  = min_wrap ? 6'd0 : min_q + 6'd1;
        if (min_wrap)  hour_d = hour_wrap ? 5'd0 : hour_q + 5'd1;
        if (hour_wrap) day_d  = day_wrap ? 5'd1 : day_q + 5'd1;
        if (day_wrap)  mon_d  = mon_wrap ? 4'd1 : mon_q + 4'd1;
        if (mon_wrap)  year_d = year_wrap ? 14'd0 : year_q + 14'd1;
      end
      FUNC_SET_DATE: begin
        out_d.accepted = cmd.load;
        if (cmd.load) begin
          day_d  = cmd.day;
          mon_d  = cmd.month;
          year_d = cmd.year;
        end
      end
      FUNC_SET_TIME: begin
        out_d.accepted = cmd.load;
        if (cmd.load) begin
          hour_d = cmd.hour;
          min_d  = cmd.min;
          sec_d  = cmd.sec;
        end
      end
      default: ;
    endcase

    out_d.second_now = sec_d;
    out_d.minute_now = min_d;
    out_d.hour_now   = hour_d;
    out_d.day_now    = day_d;
    out_d.month_now  = mon_d;
    out_d.year_now   = year_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q       <= 6'd0;
      min_q       <= 6'd0;
      hour_q      <= 5'd0;
      day_q       <= 5'd1;
      mon_q       <= 4'd1;
      year_q      <= 14'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) out_valid_q <= cmd_valid;
      if (fire) begin
        sec_q  <= sec_d;
        min_q  <= min_d;
        hour_q <= hour_d;
        day_q  <= day_d;
        mon_q  <= mon_d;
        year_q <= year_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `CCC_ASSERT_NEXT(a_tick_rollover, clk_i, rst_ni,
    fire && (cmd.func == FUNC_TICK) && (sec_q == SEC_MAX),
    out_q.minute_done && (out_q.second_now == 6'd0) && (min_q == out_q.minute_now),
    "tick at 59 s did not roll the minute")
  `CCC_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, !fire,
    $stable(sec_q) && $stable(min_q) && $stable(hour_q) && $stable(day_q) &&
    $stable(mon_q) && $stable(year_q),
    "clock state changed without a command")
  `CCC_ASSERT_IMPLY(a_state_range, clk_i, rst_ni, 1'b1,
    (hour_q <= HOUR_MAX) && (day_q >= 5'd1) && (day_q <= days_in(mon_q)) &&
    (mon_q >= 4'd1) && (mon_q <= MONTH_MAX) && (year_q <= YEAR_MAX),
    "clock state out of range")
  `CCC_ASSERT_IMPLY(a_done_tick, clk_i, rst_ni, out_valid_q && out_q.minute_done,
    out_q.accepted && (out_q.second_now == 6'd0),
    "minute flag on a beat that is not a rolled tick")

endmodule

`default_nettype wire

[src/ccc_decode.sv]
// ----------------------------------------------------------------------------
// Calendar clock set-value splitter
// Four-stage pipeline that splits DDMMYYYY / HHMMSS and range-checks it.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_decode
  import ccc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_i,
  output logic      cmd_valid_o,
  input  wire logic cmd_take_i,
  output cmd_t      cmd_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // stage 1: input register
  logic [1:0]  func1_q;
  logic [26:0] val1_q;
  // stage 2
  logic [1:0]  func2_q;
  logic [26:0] val2_q;
  logic [13:0] q2_q;
  // stage 3
  logic [1:0]  func3_q;
  logic [13:0] q3_q;
  logic [13:0] r3_q;
  logic [7:0]  hi3_q;
  // stage 4
  logic [1:0]  func4_q;
  logic [13:0] q4_q;
  logic [13:0] r4_q;
  logic [7:0]  hi4_q;
  logic [6:0]  lo4_q;
  logic [6:0]  mi4_q;

  // bubble-collapsing ready chain
  assign en4        = !v4_q || cmd_take_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  // value / 10000
  logic [54:0] prod_tenk;
  assign prod_tenk = {27'd0, RECIP_TENK} * {28'd0, val1_q};

  // remainder of 10000 and quotient / 100
  logic [26:0] scaled2;
  logic [26:0] rem2;
  logic [28:0] prod_hi;
  assign scaled2 = {13'd0, q2_q} * 27'd10000;
  assign rem2    = val2_q - scaled2;
  assign prod_hi = {14'd0, RECIP_HUNDRED} * {15'd0, q2_q};

  // low two digits of the quotient, and remainder / 100
  logic [13:0] hi_x100;
  logic [13:0] lo_full;
  logic [28:0] prod_mi;
  assign hi_x100 = {6'd0, hi3_q} * 14'd100;
  assign lo_full = q3_q - hi_x100;
  assign prod_mi = {14'd0, RECIP_HUNDRED} * {15'd0, r3_q};

  // last digits pair and range check
  logic [13:0] mi_x100;
  logic [13:0] s_full;
  logic [6:0]  sec4;
  logic        date_ok;
  logic        time_ok;
  cmd_t        cmd_d;
  assign mi_x100 = {7'd0, mi4_q} * 14'd100;
  assign s_full  = r4_q - mi_x100;
  assign sec4    = s_full[6:0];

  always_comb begin
    date_ok = (lo4_q >= 7'd1) && (lo4_q <= 7'd12) && (hi4_q >= 8'd1) &&
              (hi4_q <= {3'd0, days_in(lo4_q[3:0])});
    time_ok = (q4_q <= 14'd23) && (mi4_q <= 7'd59) && (sec4 <= 7'd59);
    cmd_d.func  = func4_q;
    cmd_d.sec   = sec4[5:0];
    cmd_d.min   = mi4_q[5:0];
    cmd_d.hour  = q4_q[4:0];
    cmd_d.day   = hi4_q[4:0];
    cmd_d.month = lo4_q[3:0];
    cmd_d.year  = r4_q;
    case (func4_q)
      FUNC_SET_DATE: cmd_d.load = date_ok;
      FUNC_SET_TIME: cmd_d.load = time_ok;
      default:       cmd_d.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      func1_q <= in_i.func;
      val1_q  <= in_i.set_value;
    end
    if (en2 && v1_q) begin
      func2_q <= func1_q;
      val2_q  <= val1_q;
      q2_q    <= prod_tenk[SHIFT_TENK +: 14];
    end
    if (en3 && v2_q) begin
      func3_q <= func2_q;
      q3_q    <= q2_q;
      r3_q    <= rem2[13:0];
      hi3_q   <= prod_hi[SHIFT_HUNDRED +: 8];
    end
    if (en4 && v3_q) begin
      func4_q <= func3_q;
      q4_q    <= q3_q;
      r4_q    <= r3_q;
      hi4_q   <= hi3_q;
      lo4_q   <= lo_full[6:0];
      mi4_q   <= prod_mi[SHIFT_HUNDRED +: 7];
    end
  end

  // stage 4 output is the command
  assign cmd_valid_o = v4_q;
  assign cmd_o       = cmd_d;

endmodule

`default_nettype wire
